@@ src/bpt_pkg.sv @@
// ============================================================================
// bpt_pkg
// Shared types, constants and helpers for the barometric compensation core.
// ============================================================================
package bpt_pkg;

    localparam int MUL_LAT  = 2;                       // 64-bit multiplier
    localparam int DIV_LAT  = 66;                      // sign prep + 64 bits + fixup
    localparam int PIPE_LAT = 5 + 2 * MUL_LAT + 1 + MUL_LAT + DIV_LAT + 2 * MUL_LAT + 1;

    typedef enum logic [1:0] {
        CFG_TRIM_TEMP    = 2'd0,
        CFG_TRIM_PRESS_A = 2'd1,
        CFG_TRIM_PRESS_B = 2'd2,
        CFG_TRIM_PRESS_C = 2'd3
    } t_cfg_idx;

    localparam logic signed [31:0] TEMP_MIN = -32'sd4000;
    localparam logic signed [31:0] TEMP_MAX = 32'sd8500;
    localparam logic [63:0] FINE_OFS  = 64'd128000;
    localparam logic [63:0] P_BASE    = 64'd1048576;
    localparam logic [63:0] P_SCALE   = 64'd3125;
    localparam logic [63:0] X1_BIAS   = 64'h0000_8000_0000_0000;

    // words riding along with the divider
    typedef struct packed {
        logic [14:0] temp;
        logic        ok;
    } t_side;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage

@@ src/bpt_mul.sv @@
// ============================================================================
// bpt_mul
// Two-stage 64x64 multiplier, low 64 bits of the product (wraps mod 2^64).
// ============================================================================
module bpt_mul
    import bpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic [63:0] n_ll;
    logic [63:0] n_lh;
    logic [63:0] n_hl;

    always_comb begin
        n_ll = i_a[31:0]  * i_b[31:0];
        n_lh = i_a[31:0]  * i_b[63:32];
        n_hl = i_a[63:32] * i_b[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh[31:0];
            r_hl <= n_hl[31:0];
            r_p  <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

@@ src/bpt_div.sv @@
// ============================================================================
// bpt_div
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ============================================================================
module bpt_div
    import bpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  t_side       i_side,
    output logic [63:0] o_quo,
    output t_side       o_side
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] work;   // dividend bits shift out, quotient bits shift in
        logic [63:0] den;
        logic        sgn;
        t_side       side;
    } t_dstg;

    t_dstg       r_st [0:64];
    logic [63:0] r_quo;
    t_side       r_side;

    // sign prep: magnitudes (2^63 fits unsigned)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem  <= '0;
            r_st[0].work <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_st[0].den  <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_st[0].sgn  <= i_num[63] ^ i_den[63];
            r_st[0].side <= i_side;
        end
    end

    for (genvar j = 0; j < 64; j++) begin : g_bit
        logic [64:0] trial;
        logic [64:0] diff;
        logic        take;

        always_comb begin
            trial = {r_st[j].rem, r_st[j].work[63]};
            diff  = trial - {1'b0, r_st[j].den};
            take  = (trial >= {1'b0, r_st[j].den});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j+1].rem  <= take ? diff[63:0] : trial[63:0];
                r_st[j+1].work <= {r_st[j].work[62:0], take};
                r_st[j+1].den  <= r_st[j].den;
                r_st[j+1].sgn  <= r_st[j].sgn;
                r_st[j+1].side <= r_st[j].side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo  <= r_st[64].sgn ? (64'd0 - r_st[64].work) : r_st[64].work;
            r_side <= r_st[64].side;
        end
    end

    assign o_quo  = r_quo;
    assign o_side = r_side;

endmodule

@@ src/baro_pressure_temp_compensation_core.sv @@
// ============================================================================
// baro_pressure_temp_compensation_core
// Integer trim compensation of raw barometer pressure and temperature words.
// ============================================================================
// One input word (raw pressure, raw temperature) gives one output word: the
// temperature in 0.01 degC clamped to -4000..8500, the pressure in Pa as
// Q24.8 clamped to 0..2^32-1, and pressure_ok (0 when the pressure divisor
// is zero, pressure then reads 0). The core is a fixed pipeline that takes a
// new word every cycle unless o_stall is high; most of its registers belong
// to the bit-per-stage 64-bit divider (66 stages). The whole pipe
// advances together: it moves whenever the output register is empty or
// taken, so o_stall is simply "output full and stalled". Trim registers are
// written through a plain write port and must only change while idle.
// ============================================================================
module baro_pressure_temp_compensation_core
    import bpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [14:0] o_temp_centideg,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_pressure_ok
);

    // ---------------------------------------------------------------- trims
    logic [47:0] r_trim_temp;
    logic [63:0] r_trim_pa;
    logic [63:0] r_trim_pb;
    logic [15:0] r_trim_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_temp <= '0;
            r_trim_pa   <= '0;
            r_trim_pb   <= '0;
            r_trim_pc   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TRIM_TEMP:    r_trim_temp <= i_cfg_wdata[47:0];
                CFG_TRIM_PRESS_A: r_trim_pa   <= i_cfg_wdata;
                CFG_TRIM_PRESS_B: r_trim_pb   <= i_cfg_wdata;
                CFG_TRIM_PRESS_C: r_trim_pc   <= i_cfg_wdata[15:0];
                default:          r_trim_pc   <= r_trim_pc;
            endcase
        end
    end

    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'd0, r_trim_temp[15:0]};
    assign t2 = {{16{r_trim_temp[31]}}, r_trim_temp[31:16]};
    assign t3 = {{16{r_trim_temp[47]}}, r_trim_temp[47:32]};
    assign p1 = {48'd0, r_trim_pa[15:0]};
    assign p2 = sx16(r_trim_pa[31:16]);
    assign p3 = sx16(r_trim_pa[47:32]);
    assign p4 = sx16(r_trim_pa[63:48]);
    assign p5 = sx16(r_trim_pb[15:0]);
    assign p6 = sx16(r_trim_pb[31:16]);
    assign p7 = sx16(r_trim_pb[47:32]);
    assign p8 = sx16(r_trim_pb[63:48]);
    assign p9 = sx16(r_trim_pc);

    // ------------------------------------------------------- flow control
    logic                r_out_vld;
    logic [PIPE_LAT-1:0] r_vld;
    logic                adv;

    assign r_out_vld = r_vld[PIPE_LAT-1];
    assign adv       = !r_out_vld || !i_stall;
    assign o_stall   = r_out_vld && i_stall;
    assign o_valid   = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // ------------------------------------------------ temperature, k0..k4
    logic [19:0] r_adcp [0:8];     // raw pressure, k0..k8
    logic [19:0] r_adct;
    logic [31:0] r_prod_a, r_prod_bb;
    logic signed [31:0] r_v1;
    logic [31:0] r_c;
    logic signed [31:0] r_fine;
    logic [14:0] r_temp [0:7];     // k4..k11
    logic [63:0] r_x1;

    logic [31:0] n_a, n_b, n_bb_sh, n_f5;
    logic signed [31:0] n_t, n_tc;

    always_comb begin
        n_a     = {15'd0, r_adct[19:3]} - {t1[30:0], 1'b0};
        n_b     = {16'd0, r_adct[19:4]} - t1;
        n_bb_sh = 32'($signed(r_prod_bb) >>> 12);
        n_f5    = {r_fine[29:0], 2'b00} + r_fine + 32'd128;
        n_t     = $signed(n_f5) >>> 8;
        if (n_t < TEMP_MIN) begin
            n_tc = TEMP_MIN;
        end else if (n_t > TEMP_MAX) begin
            n_tc = TEMP_MAX;
        end else begin
            n_tc = n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_adct    <= i_raw_temperature;
            r_adcp[0] <= i_raw_pressure;
            for (int k = 1; k < 9; k++) begin
                r_adcp[k] <= r_adcp[k-1];
            end
            r_prod_a  <= n_a * t2;
            r_prod_bb <= n_b * n_b;
            r_v1      <= $signed(r_prod_a) >>> 11;
            r_c       <= n_bb_sh * t3;
            r_fine    <= r_v1 + ($signed(r_c) >>> 14);
            r_temp[0] <= n_tc[14:0];
            for (int k = 1; k < 8; k++) begin
                r_temp[k] <= r_temp[k-1];
            end
            r_x1      <= {{32{r_fine[31]}}, r_fine} - FINE_OFS;
        end
    end

    // ------------------------------------------------- pressure terms
    logic [63:0] w_sq, w_x1p5, w_x1p2, w_sqp6, w_sqp3;
    logic [63:0] r_x1p5 [0:1];
    logic [63:0] r_x1p2 [0:1];

    bpt_mul u_mul_sq  (.i_clk, .i_en(adv), .i_a(r_x1), .i_b(r_x1), .o_p(w_sq));
    bpt_mul u_mul_p5  (.i_clk, .i_en(adv), .i_a(r_x1), .i_b(p5),   .o_p(w_x1p5));
    bpt_mul u_mul_p2  (.i_clk, .i_en(adv), .i_a(r_x1), .i_b(p2),   .o_p(w_x1p2));
    bpt_mul u_mul_p6  (.i_clk, .i_en(adv), .i_a(w_sq), .i_b(p6),   .o_p(w_sqp6));
    bpt_mul u_mul_p3  (.i_clk, .i_en(adv), .i_a(w_sq), .i_b(p3),   .o_p(w_sqp3));

    logic [63:0] r_x1b, r_n0;
    logic [63:0] n_x2, n_p0;

    always_comb begin
        n_x2 = w_sqp6 + {r_x1p5[1][46:0], 17'd0} + {p4[28:0], 35'd0};
        n_p0 = P_BASE - {44'd0, r_adcp[8]};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x1p5[0] <= w_x1p5;
            r_x1p5[1] <= r_x1p5[0];
            r_x1p2[0] <= w_x1p2;
            r_x1p2[1] <= r_x1p2[0];
            r_x1b     <= 64'($signed(w_sqp3) >>> 8) + {r_x1p2[1][51:0], 12'd0};
            r_n0      <= {n_p0[32:0], 31'd0} - n_x2;
        end
    end

    logic [63:0] w_den_raw, w_num;
    logic [63:0] w_den;
    t_side       w_side_in;

    bpt_mul u_mul_p1  (.i_clk, .i_en(adv), .i_a(X1_BIAS + r_x1b), .i_b(p1),
                       .o_p(w_den_raw));
    bpt_mul u_mul_sc  (.i_clk, .i_en(adv), .i_a(r_n0), .i_b(P_SCALE), .o_p(w_num));

    assign w_den          = 64'($signed(w_den_raw) >>> 33);
    assign w_side_in.temp = r_temp[7];
    assign w_side_in.ok   = (w_den != 64'd0);

    // ------------------------------------------------------------ divide
    logic [63:0] w_quo;
    t_side       w_side_out;

    bpt_div u_div (
        .i_clk,
        .i_en   (adv),
        .i_num  (w_num),
        .i_den  (w_den),
        .i_side (w_side_in),
        .o_quo  (w_quo),
        .o_side (w_side_out)
    );

    // ------------------------------------------------- second-order terms
    logic [63:0] w_s, w_ss, w_p8q, w_p9ss;
    logic [63:0] r_q [0:3];
    t_side       r_side [0:3];
    logic [63:0] r_p8q [0:1];

    assign w_s = 64'($signed(w_quo) >>> 13);

    bpt_mul u_mul_ss  (.i_clk, .i_en(adv), .i_a(w_s),   .i_b(w_s),  .o_p(w_ss));
    bpt_mul u_mul_p8  (.i_clk, .i_en(adv), .i_a(p8),    .i_b(w_quo), .o_p(w_p8q));
    bpt_mul u_mul_p9  (.i_clk, .i_en(adv), .i_a(p9),    .i_b(w_ss), .o_p(w_p9ss));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q[0]    <= w_quo;
            r_side[0] <= w_side_out;
            for (int k = 1; k < 4; k++) begin
                r_q[k]    <= r_q[k-1];
                r_side[k] <= r_side[k-1];
            end
            r_p8q[0] <= w_p8q;
            r_p8q[1] <= r_p8q[0];
        end
    end

    // ------------------------------------------------ final sum and clamp
    logic [63:0] n_sum, n_pf;
    logic [31:0] n_press;

    always_comb begin
        n_sum = r_q[3] + 64'($signed(w_p9ss) >>> 25) + 64'($signed(r_p8q[1]) >>> 19);
        n_pf  = 64'($signed(n_sum) >>> 8) + {p7[59:0], 4'd0};
        if (!r_side[3].ok || n_pf[63]) begin
            n_press = '0;
        end else if (|n_pf[62:32]) begin
            n_press = '1;
        end else begin
            n_press = n_pf[31:0];
        end
    end

    logic [14:0] r_o_temp;
    logic [31:0] r_o_press;
    logic        r_o_ok;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_temp  <= r_side[3].temp;
            r_o_press <= n_press;
            r_o_ok    <= r_side[3].ok;
        end
    end

    assign o_temp_centideg  = $signed(r_o_temp);
    assign o_pressure_q24_8 = r_o_press;
    assign o_pressure_ok    = r_o_ok;

endmodule

@@ src/bpt_chk.sv @@
// ============================================================================
// bpt_chk
// Port-level checks for the compensation core, bound to the top level.
// ============================================================================
module bpt_chk
    import bpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic signed [14:0] o_temp_centideg,
    input  logic [31:0] o_pressure_q24_8,
    input  logic        o_pressure_ok
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_temp_centideg)
            && $stable(o_pressure_q24_8) && $stable(o_pressure_ok))
        else $error("output word changed while stalled");

    // input side only backs up when the output is full and stalled
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // bad divisor reads as zero pressure
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pressure_ok |-> o_pressure_q24_8 == 32'd0)
        else $error("pressure nonzero with pressure_ok low");

    // temperature clamp
    a_temp_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_temp_centideg >= -15'sd4000 && o_temp_centideg <= 15'sd8500)
        else $error("temperature out of range");

endmodule

bind baro_pressure_temp_compensation_core bpt_chk u_bpt_chk (
    .i_clk,
    .i_rst_n,
    .o_stall,
    .o_valid,
    .i_stall,
    .o_temp_centideg,
    .o_pressure_q24_8,
    .o_pressure_ok
);
